// File: hdl/oswo_pkg.sv
package oswo_pkg;

  localparam int SYM_MAX_DEFAULT = 1024;
  localparam int WIN_SHIFT       = 13;

  localparam int SYM_LEN_W = 11;
  localparam int CP_LEN_W  = 10;
  localparam int WEIGHT_W  = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [SYM_LEN_W-1:0] SYM_LEN_RESET  = 11'd640;
  localparam logic [CP_LEN_W-1:0]  CP_LEN_RESET   = 10'd128;
  localparam logic [WEIGHT_W-1:0]  WEIGHT0_RESET  = 14'd1200;
  localparam logic [WEIGHT_W-1:0]  WEIGHT1_RESET  = 14'd4096;
  localparam logic [WEIGHT_W-1:0]  WEIGHT2_RESET  = 14'd6992;

  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CP_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO  = 3'd4;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TAIL   = 2'd1;
  localparam logic [1:0] KIND_DRAIN  = 2'd2;

  localparam logic [1:0] TAIL_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic [1:0]         tail_index;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
    logic               out_last;
  } result_t;

endpackage

// File: hdl/ofdm_symbol_window_overlap.sv
// Each result passes the stage-one, stage-two and output registers after its item is accepted.
// Throughput: one item per cycle while item_stall is low; a stalled result lets up to two
// more results queue behind it. A write to sym_len or cp_len re-reads the six tail samples
// through the second store read port, holding item_stall high while the refresh runs.
// Reset (rst, synchronous): counters, bank select, valid flags and tail_for_held entries clear;
// held_tail, load_tail and symbol store contents are undefined until written.
module ofdm_symbol_window_overlap #(
  parameter int SYM_MAX = oswo_pkg::SYM_MAX_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  oswo_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output oswo_pkg::result_t                     result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [oswo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [oswo_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import oswo_pkg::*;

  localparam int CW        = $clog2(SYM_MAX);
  localparam int LW        = $clog2(SYM_MAX + 1);
  localparam int AW        = CW + 1;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int PW        = 16 + WEIGHT_W + 1;
  localparam int SW        = PW + 1;

  localparam logic [LW-1:0] LEN_MIN = LW'(8);
  localparam logic [LW-1:0] LEN_MAX = LW'(SYM_MAX);
  localparam logic [2:0]    RF_PASS = 3'd3;
  localparam logic [2:0]    RF_LAST = 3'd5;

  logic [SYM_LEN_W-1:0] sym_len;
  logic [CP_LEN_W-1:0]  cp_len;
  logic [WEIGHT_W-1:0]  weight_zero;
  logic [WEIGHT_W-1:0]  weight_one;
  logic [WEIGHT_W-1:0]  weight_two;

  logic [CW-1:0] write_count;
  logic [CW-1:0] read_count;
  logic          load_bank;
  logic          held_valid;
  logic [31:0]   tail_for_held [3];
  logic [31:0]   held_tail [3];
  logic [31:0]   load_tail [3];
  logic [31:0]   load_tail_next [3];

  logic [31:0] store_mem [MEM_DEPTH];
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;

  logic [LW-1:0] eff_len;
  logic [LW-1:0] eff_cp;
  logic [LW-1:0] cp_lim;

  logic          cfg_we;
  logic          rf_start;
  logic          rf_busy;
  logic [2:0]    rf_step;
  logic          rf_land;
  logic [2:0]    rf_land_step;
  logic [1:0]    rf_sel;
  logic [1:0]    rf_land_sel;
  logic          rf_bank;
  logic [LW-1:0] rf_pos;
  logic [AW-1:0] raddr_b;

  logic          en1;
  logic          en2;
  logic          en3;
  logic          item_acc;
  logic          is_sample;
  logic          emit;
  logic          swap;
  logic          last;
  logic          mix;
  logic [LW-1:0] rd_next;
  logic [LW-1:0] wr_next;
  logic [LW-1:0] head_pos;
  logic [CW-1:0] pos;
  logic [AW-1:0] raddr_a;
  logic [31:0]   sample_word;
  logic [1:0]    tail_sel;
  logic [WEIGHT_W-1:0] wn;
  logic [WEIGHT_W-1:0] wp;

  logic                v1;
  logic                s1_mix;
  logic                s1_last;
  logic [WEIGHT_W-1:0] s1_wn;
  logic [WEIGHT_W-1:0] s1_wp;
  logic [31:0]         s1_tail;

  logic                v2;
  logic                s2_mix;
  logic                s2_last;
  logic [31:0]         s2_x;
  logic signed [PW-1:0] s2_pxr;
  logic signed [PW-1:0] s2_pxi;
  logic signed [PW-1:0] s2_ptr;
  logic signed [PW-1:0] s2_pti;

  logic signed [PW-1:0] xr_ext;
  logic signed [PW-1:0] xi_ext;
  logic signed [PW-1:0] tr_ext;
  logic signed [PW-1:0] ti_ext;
  logic signed [PW-1:0] wn_ext;
  logic signed [PW-1:0] wp_ext;
  logic signed [SW-1:0] sum_re;
  logic signed [SW-1:0] sum_im;
  logic signed [SW-1:0] sh_re;
  logic signed [SW-1:0] sh_im;

  // effective lengths
  always_comb begin
    if (sym_len < SYM_LEN_W'(8)) begin
      eff_len = LEN_MIN;
    end else if (32'(sym_len) > SYM_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = LW'(sym_len);
    end
    cp_lim = eff_len - LW'(3);
    if (32'(cp_len) > 32'(cp_lim)) begin
      eff_cp = cp_lim;
    end else begin
      eff_cp = LW'(cp_len);
    end
  end

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign rf_start  = cfg_we && (cfg_index == CFG_SYM_LEN || cfg_index == CFG_CP_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_len     <= SYM_LEN_RESET;
      cp_len      <= CP_LEN_RESET;
      weight_zero <= WEIGHT0_RESET;
      weight_one  <= WEIGHT1_RESET;
      weight_two  <= WEIGHT2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYM_LEN:     sym_len     <= cfg_data[SYM_LEN_W-1:0];
        CFG_CP_LEN:      cp_len      <= cfg_data[CP_LEN_W-1:0];
        CFG_WEIGHT_ZERO: weight_zero <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_ONE:  weight_one  <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_TWO:  weight_two  <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // tail refresh sequencer
  always_comb begin
    rf_bank     = (rf_step >= RF_PASS) ? load_bank : ~load_bank;
    rf_sel      = (rf_step >= RF_PASS) ? 2'(rf_step - RF_PASS) : rf_step[1:0];
    rf_land_sel = (rf_land_step >= RF_PASS) ? 2'(rf_land_step - RF_PASS)
                                            : rf_land_step[1:0];
    case (rf_sel)
      2'd0:    rf_pos = eff_len - LW'(2);
      2'd1:    rf_pos = eff_len - LW'(1);
      default: rf_pos = eff_cp;
    endcase
    raddr_b = {rf_bank, rf_pos[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_busy <= 1'b0;
      rf_step <= '0;
      rf_land <= 1'b0;
    end else begin
      rf_land <= rf_busy;
      if (rf_start) begin
        rf_busy <= 1'b1;
        rf_step <= '0;
      end else if (rf_busy) begin
        if (rf_step == RF_LAST) begin
          rf_busy <= 1'b0;
        end
        rf_step <= rf_step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rf_land_step <= rf_step;
  end

  // pipeline flow
  assign en3        = !result_valid || !result_stall;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1 || rf_busy || rf_land;
  assign item_acc   = item_valid && !item_stall;

  assign sample_word = {item.sample_imag, item.sample_real};
  assign is_sample   = item_acc && item.kind == KIND_SAMPLE;
  assign emit        = item_acc && held_valid &&
                       (item.kind == KIND_SAMPLE || item.kind == KIND_DRAIN);

  always_comb begin
    rd_next  = LW'(read_count) + LW'(1);
    wr_next  = LW'(write_count) + LW'(1);
    last     = rd_next >= eff_len;
    swap     = is_sample && wr_next >= eff_len;
    mix      = read_count < CW'(3);
    head_pos = eff_len - eff_cp - LW'(2) + LW'(read_count);
    pos      = (read_count < CW'(2)) ? head_pos[CW-1:0] : read_count - CW'(2);
    raddr_a  = {~load_bank, pos};
    tail_sel = mix ? read_count[1:0] : 2'd0;
    case (tail_sel)
      2'd0: begin
        wn = weight_zero;
        wp = weight_two;
      end
      2'd1: begin
        wn = weight_one;
        wp = weight_one;
      end
      default: begin
        wn = weight_two;
        wp = weight_zero;
      end
    endcase
    load_tail_next = load_tail;
    if (is_sample) begin
      if (LW'(write_count) == eff_len - LW'(2)) begin
        load_tail_next[0] = sample_word;
      end
      if (LW'(write_count) == eff_len - LW'(1)) begin
        load_tail_next[1] = sample_word;
      end
      if (LW'(write_count) == eff_cp) begin
        load_tail_next[2] = sample_word;
      end
    end
  end

  // symbol store
  always_ff @(posedge clk) begin
    if (is_sample) begin
      store_mem[{load_bank, write_count}] <= sample_word;
    end
    if (en1) begin
      rdata_a <= store_mem[raddr_a];
    end
    if (rf_busy) begin
      rdata_b <= store_mem[raddr_b];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_count  <= '0;
      load_bank   <= 1'b0;
      held_valid  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tail_for_held[i] <= '0;
      end
    end else begin
      if (is_sample) begin
        write_count <= swap ? '0 : wr_next[CW-1:0];
      end
      if (swap) begin
        load_bank  <= ~load_bank;
        held_valid <= 1'b1;
        read_count <= '0;
      end else if (emit) begin
        read_count <= last ? '0 : rd_next[CW-1:0];
        if (last) begin
          held_valid <= 1'b0;
        end
      end
      if (emit && last) begin
        tail_for_held <= held_tail;
      end else if (item_acc && item.kind == KIND_TAIL && item.tail_index != TAIL_NONE) begin
        tail_for_held[item.tail_index] <= sample_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_land) begin
      if (rf_land_step >= RF_PASS) begin
        load_tail[rf_land_sel] <= rdata_b;
      end else begin
        held_tail[rf_land_sel] <= rdata_b;
      end
    end else begin
      if (is_sample) begin
        load_tail <= load_tail_next;
      end
      if (swap) begin
        held_tail <= load_tail_next;
      end
    end
  end

  // stage 1: store read, weights and tail
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mix  <= mix;
      s1_last <= last;
      s1_wn   <= wn;
      s1_wp   <= wp;
      s1_tail <= tail_for_held[tail_sel];
    end
  end

  // stage 2: products
  always_comb begin
    xr_ext = PW'($signed(rdata_a[15:0]));
    xi_ext = PW'($signed(rdata_a[31:16]));
    tr_ext = PW'($signed(s1_tail[15:0]));
    ti_ext = PW'($signed(s1_tail[31:16]));
    wn_ext = PW'($signed({1'b0, s1_wn}));
    wp_ext = PW'($signed({1'b0, s1_wp}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mix  <= s1_mix;
      s2_last <= s1_last;
      s2_x    <= rdata_a;
      s2_pxr  <= xr_ext * wn_ext;
      s2_pxi  <= xi_ext * wn_ext;
      s2_ptr  <= tr_ext * wp_ext;
      s2_pti  <= ti_ext * wp_ext;
    end
  end

  // stage 3: sum, shift, output register
  always_comb begin
    sum_re = SW'(s2_pxr) + SW'(s2_ptr);
    sum_im = SW'(s2_pxi) + SW'(s2_pti);
    sh_re  = sum_re >>> WIN_SHIFT;
    sh_im  = sum_im >>> WIN_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result.out_real <= s2_mix ? sh_re[15:0] : s2_x[15:0];
      result.out_imag <= s2_mix ? sh_im[15:0] : s2_x[31:16];
      result.out_last <= s2_last;
    end
  end

`ifndef ASSERT_OFF
  a_swap_holds: assert property (@(posedge clk) disable iff (rst)
    swap |=> (held_valid && read_count == '0))
    else $error("completed symbol not taken as held");

  a_last_drops: assert property (@(posedge clk) disable iff (rst)
    (emit && last && !swap) |=> !held_valid)
    else $error("held symbol still valid after its last output");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en1) |=> (v1 && $stable(rdata_a) && $stable(s1_last)))
    else $error("stage one lost its data while stalled");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
  import oswo_pkg::*;

  localparam int SYM = SYM_MAX_DEFAULT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  ofdm_symbol_window_overlap uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [SYM_LEN_W-1:0] len_reg = SYM_LEN_RESET;
  logic [CP_LEN_W-1:0] prefix_reg = CP_LEN_RESET;
  logic [WEIGHT_W-1:0] weight_reg [3] = '{WEIGHT0_RESET, WEIGHT1_RESET, WEIGHT2_RESET};
  logic [31:0] sym_mem [2*SYM];
  int unsigned load_count = 0;
  bit load_bank = 1'b0;
  bit held = 1'b0;
  int unsigned play_count = 0;
  logic [31:0] tail_reg [3] = '{32'd0, 32'd0, 32'd0};
  result_t window_out_q [$];
  int unsigned fault_count = 0;
  bit item_steady = 1'b0;
  bit sink_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void note_error(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int unsigned eff_length(input logic [SYM_LEN_W-1:0] v);
    int unsigned l;
    l = v;
    if (l < 8) l = 8;
    if (l > SYM) l = SYM;
    return l;
  endfunction

  function automatic int unsigned eff_prefix(input int unsigned l);
    int unsigned c;
    c = prefix_reg;
    if (c > l - 3) c = l - 3;
    return c;
  endfunction

  function automatic logic [15:0] window_mix(input logic [15:0] x, input logic [15:0] t,
                                             input int unsigned wn, input int unsigned wp);
    longint acc;
    acc = longint'($signed(x)) * longint'(wn) + longint'($signed(t)) * longint'(wp);
    acc = acc >>> WIN_SHIFT;
    return acc[15:0];
  endfunction

  function automatic void emit_window_sample();
    int unsigned l;
    int unsigned c;
    int unsigned r;
    int unsigned pos;
    int unsigned base;
    logic [31:0] s;
    result_t res;
    l = eff_length(len_reg);
    c = eff_prefix(l);
    base = load_bank ? 0 : SYM;
    r = play_count;
    pos = (r < 2) ? (l - c - 2 + r) : (r - 2);
    s = sym_mem[base + (pos % SYM)];
    res.out_real = s[15:0];
    res.out_imag = s[31:16];
    if (r < 3) begin
      res.out_real = window_mix(s[15:0], tail_reg[r][15:0], weight_reg[r], weight_reg[2-r]);
      res.out_imag = window_mix(s[31:16], tail_reg[r][31:16], weight_reg[r], weight_reg[2-r]);
    end
    play_count = r + 1;
    res.out_last = (play_count >= l);
    window_out_q.push_back(res);
    if (res.out_last) begin
      tail_reg[0] = sym_mem[base + ((l - 2) % SYM)];
      tail_reg[1] = sym_mem[base + ((l - 1) % SYM)];
      tail_reg[2] = sym_mem[base + (c % SYM)];
      held = 1'b0;
      play_count = 0;
    end
  endfunction

  function automatic void predict_window(input item_t it);
    logic [31:0] s;
    int unsigned wc;
    s = {it.sample_imag, it.sample_real};
    case (it.kind)
      KIND_TAIL: begin
        if (it.tail_index != TAIL_NONE) tail_reg[it.tail_index] = s;
      end
      KIND_DRAIN: begin
        if (held) emit_window_sample();
      end
      KIND_SAMPLE: begin
        if (held) emit_window_sample();
        wc = load_count % SYM;
        sym_mem[int'(load_bank) * SYM + wc] = s;
        load_count = wc + 1;
        if (load_count >= eff_length(len_reg)) begin
          load_bank = ~load_bank;
          held = 1'b1;
          load_count = 0;
          play_count = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'hFFFF;
      3: v = 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic item_t make_item(input logic [1:0] k, input logic [15:0] re,
                                      input logic [15:0] im, input logic [1:0] ti);
    item_t it;
    it.kind = k;
    it.sample_real = re;
    it.sample_imag = im;
    it.tail_index = ti;
    return it;
  endfunction

  function automatic item_t random_sample();
    return make_item(KIND_SAMPLE, rand_half(), rand_half(), 2'($urandom_range(0, 3)));
  endfunction

  function automatic item_t traffic_item();
    item_t it;
    int unsigned pick;
    it = random_sample();
    pick = $urandom_range(0, 99);
    if (pick < 8) it.kind = KIND_DRAIN;
    else if (pick < 13) it.kind = KIND_TAIL;
    else if (pick < 15) it.kind = KIND_UNUSED;
    return it;
  endfunction

  function automatic logic [15:0] weight_word();
    logic [15:0] w;
    case ($urandom_range(0, 4))
      0: w = 16'd0;
      1: w = 16'd8192;
      2: w = 16'h3FFF;
      default: w = 16'($urandom_range(0, 8192));
    endcase
    w[15:14] = 2'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = item_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    predict_window(it);
    if ($urandom_range(0, 63) == 0) item_steady = ~item_steady;
  endtask

  task automatic send_samples(input int unsigned n);
    repeat (n) send_item(random_sample());
  endtask

  task automatic send_drains(input int unsigned n);
    repeat (n) begin
      send_item(make_item(KIND_DRAIN, rand_half(), rand_half(), 2'($urandom_range(0, 3))));
    end
  endtask

  task automatic drain_held();
    while (held) begin
      send_item(make_item(KIND_DRAIN, rand_half(), rand_half(), 2'($urandom_range(0, 3))));
    end
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    item_valid = 1'b0;
    while (window_out_q.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (window_out_q.size() != 0) begin
      note_error($sformatf("%0d expected outputs never arrived", window_out_q.size()));
      window_out_q.delete();
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    item_valid = 1'b0;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SYM_LEN: len_reg = data[SYM_LEN_W-1:0];
      CFG_CP_LEN: prefix_reg = data[CP_LEN_W-1:0];
      CFG_WEIGHT_ZERO: weight_reg[0] = data[WEIGHT_W-1:0];
      CFG_WEIGHT_ONE: weight_reg[1] = data[WEIGHT_W-1:0];
      CFG_WEIGHT_TWO: weight_reg[2] = data[WEIGHT_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // finish the held symbol before growing the length
  task automatic set_length(input logic [15:0] data);
    settle();
    if (eff_length(data[SYM_LEN_W-1:0]) > eff_length(len_reg) && held) begin
      drain_held();
      settle();
    end
    write_reg(CFG_SYM_LEN, data);
  endtask

  task automatic test_reset_values();
    int i;
    for (i = 0; i < 3; i++) begin
      send_item(make_item(KIND_TAIL, rand_half(), rand_half(), i[1:0]));
    end
    send_samples(eff_length(len_reg));
    send_drains(3);
    set_length(16'd8);
    drain_held();
  endtask

  task automatic test_edge_items();
    logic [31:0] corners [8] = '{32'h8000_8000, 32'h7FFF_7FFF, 32'h0000_0000, 32'hFFFF_0001,
                                 32'h0001_FFFF, 32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_FFFF};
    settle();
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_WEIGHT_ZERO, 16'hFFFF);
    write_reg(CFG_WEIGHT_ONE, 16'hC000);
    write_reg(CFG_WEIGHT_TWO, 16'd8192);
    write_reg(CFG_CP_LEN, 16'hFFFF);
    set_length(16'hF800);
    send_item(make_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 2'd3));
    send_item(make_item(KIND_TAIL, 16'h1234, 16'h5678, TAIL_NONE));
    send_item(make_item(KIND_TAIL, 16'h8000, 16'h7FFF, 2'd0));
    send_item(make_item(KIND_TAIL, 16'h7FFF, 16'h8000, 2'd1));
    send_item(make_item(KIND_TAIL, 16'hFFFF, 16'hFFFF, 2'd2));
    send_item(make_item(KIND_DRAIN, 16'h0000, 16'h0000, 2'd0));
    repeat (2) begin
      foreach (corners[i]) begin
        send_item(make_item(KIND_SAMPLE, corners[i][15:0], corners[i][31:16],
                            2'($urandom_range(0, 3))));
      end
    end
    drain_held();
  endtask

  // push both counters past a shrunken length
  task automatic test_length_shrink();
    set_length(16'd20);
    write_reg(CFG_CP_LEN, 16'd4);
    send_samples(32);
    set_length(16'd6);
    send_samples(9);
    drain_held();
    set_length(16'd20);
    send_samples(14);
    set_length(16'd12);
    send_samples(1);
    drain_held();
  endtask

  task automatic test_longest_symbol();
    set_length(16'hFFFF);
    write_reg(CFG_CP_LEN, 16'hFE00);
    send_samples(eff_length(len_reg));
    send_drains(3);
    set_length(16'd16);
    drain_held();
  endtask

  task automatic test_random_traffic();
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] cp;
    logic [15:0] len;
    repeat (6) begin
      settle();
      if ($urandom_range(0, 1) == 1) begin
        w0 = 16'($urandom_range(0, 8192));
        w1 = 16'd4096;
        w2 = 16'd8192 - w0;
      end else begin
        w0 = weight_word();
        w1 = weight_word();
        w2 = weight_word();
      end
      write_reg(CFG_WEIGHT_ZERO, w0);
      write_reg(CFG_WEIGHT_ONE, w1);
      write_reg(CFG_WEIGHT_TWO, w2);
      cp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                       : 16'($urandom_range(0, 12));
      write_reg(CFG_CP_LEN, cp);
      len = 16'($urandom_range(0, 40));
      len[15:11] = 5'($urandom_range(0, 31));
      set_length(len);
      repeat (50) send_item(traffic_item());
    end
  endtask

  initial begin : sink_pace
    int unsigned hold;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = sink_steady ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      if ($urandom_range(0, 63) == 0) sink_steady = ~sink_steady;
    end
  end

  always @(posedge clk) begin : window_check
    result_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (window_out_q.size() == 0) begin
        note_error($sformatf("unexpected output: re %0d im %0d last %0d",
                             result.out_real, result.out_imag, result.out_last));
      end else begin
        want = window_out_q.pop_front();
        if (result.out_real !== want.out_real || result.out_imag !== want.out_imag ||
            result.out_last !== want.out_last) begin
          note_error($sformatf(
              "mismatch: want re %0d im %0d last %0d, got re %0d im %0d last %0d",
              want.out_real, want.out_imag, want.out_last,
              result.out_real, result.out_imag, result.out_last));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_edge_items();
    test_length_shrink();
    test_longest_symbol();
    test_random_traffic();
    settle();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: ofdm_symbol_window_overlap.f
hdl/oswo_pkg.sv
hdl/ofdm_symbol_window_overlap.sv
dv/tb_top.sv
